FILE: rtl/pcent_pkg.sv
// ----------------------------------------------------------------------------
// pcent_pkg
// shared widths, status codes and divider handshake type for the centroid block
// ----------------------------------------------------------------------------
package pcent_pkg;

  localparam int COORD_W = 16;
  localparam int PROD_W  = 32;
  localparam int CROSS_W = 40;
  localparam int EDGE_W  = 33;
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int MOM_W   = 56;
  localparam int DEN_W   = CROSS_W + 2;
  localparam int NUM_W   = MOM_W + 2;
  localparam int DIV_W   = DEN_W + 1;
  localparam int STEP_W  = $clog2(NUM_W);
  localparam int STAT_W  = 2;
  localparam int OUT_W   = 80;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO     = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_MANY = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/pcent_div.sv
// ----------------------------------------------------------------------------
// pcent_div
// bit-serial restoring divider: round(num / den) ties away from zero,
// saturated to signed 16 bits
// ----------------------------------------------------------------------------
module pcent_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [pcent_pkg::MOM_W-1:0]   num,
  input  logic signed [pcent_pkg::DEN_W-1:0]   den,
  output pcent_pkg::div_stat_t                 stat,
  output logic signed [pcent_pkg::COORD_W-1:0] quot
);
  import pcent_pkg::*;

  logic [NUM_W-1:0]  acc;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic              neg;
  logic              busy;
  logic              done;

  logic [MOM_W-1:0] abs_n;
  logic [DEN_W-1:0] abs_d;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   diff;
  logic             qbit;
  logic [NUM_W-1:0] q_full;

  always_comb begin
    abs_n  = num[MOM_W-1] ? MOM_W'(-num) : MOM_W'(num);
    abs_d  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    rem_sh = {rem, acc[NUM_W-1]};
    diff   = rem_sh - {1'b0, dvs};
    qbit   = !diff[DIV_W];
    q_full = {acc[NUM_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      done <= 1'b0;
      neg  <= num[MOM_W-1] ^ den[DEN_W-1];
      acc  <= {1'b0, abs_n, 1'b0} + NUM_W'(abs_d);
      dvs  <= {abs_d, 1'b0};
      rem  <= '0;
    end else if (busy) begin
      rem  <= qbit ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      acc  <= q_full;
      step <= step + 1'b1;
      if (step == STEP_W'(NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
        // saturate to the signed 16-bit range
        if (neg) begin
          quot <= (q_full > NUM_W'(32768)) ? 16'sh8000 : COORD_W'(-q_full[COORD_W-1:0]);
        end else begin
          quot <= (q_full > NUM_W'(32767)) ? 16'sh7fff : q_full[COORD_W-1:0];
        end
      end else begin
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: rtl/polygon_centroid.sv
// ----------------------------------------------------------------------------
// polygon_centroid
// shoelace centroid and doubled signed area of a polygon, one vertex a transfer
// ----------------------------------------------------------------------------
// Vertices come in on the s_ stream, x in s_tdata[15:0], y in s_tdata[31:16],
// both signed Q8.8, with s_tlast on the final vertex of a polygon. One result
// per polygon leaves on the m_ stream after the last vertex.
// A vertex that closes an edge keeps s_tready low through states S_M1 to S_M6
// while one shared 34x18 multiplier forms the two cross terms and the two moment
// products; the first vertex of a polygon is only stored and forms no edge.
// After the last vertex the closing edge back to the first vertex goes through
// the same multiplier states, then a shared bit-serial divider forms x and then y;
// a zero area or too many vertices skips the divider and gives an error status.
// The result sits in an output register: the next polygon may be sent while
// it waits, but a further result waits until the receiver has taken it, and
// input is held off meanwhile.
// rst is synchronous; it clears the accumulators, the vertex count and the
// output valid.
// ----------------------------------------------------------------------------
module polygon_centroid #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,  // vertex_x, vertex_y
  input  logic                            s_tlast,  // is_last
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pcent_pkg::OUT_W-1:0]     m_tdata   // centroid_x, centroid_y,
                                                    // twice_area, status
);
  import pcent_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 2);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_M1    = 4'd1;
  localparam logic [3:0] S_M2    = 4'd2;
  localparam logic [3:0] S_M3    = 4'd3;
  localparam logic [3:0] S_M4    = 4'd4;
  localparam logic [3:0] S_M5    = 4'd5;
  localparam logic [3:0] S_M6    = 4'd6;
  localparam logic [3:0] S_CLOSE = 4'd7;
  localparam logic [3:0] S_CHK   = 4'd8;
  localparam logic [3:0] S_DXS   = 4'd9;
  localparam logic [3:0] S_DXW   = 4'd10;
  localparam logic [3:0] S_DYS   = 4'd11;
  localparam logic [3:0] S_DYW   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state;

  logic signed [COORD_W-1:0] first_x, first_y, prev_x, prev_y;
  logic signed [COORD_W-1:0] px, py, qx, qy;
  logic signed [CROSS_W-1:0] cross_sum;
  logic signed [MOM_W-1:0]   moment_x_sum, moment_y_sum;
  logic [CNT_W-1:0]          vertex_count;
  logic                      last_r, closed;

  logic signed [MUL_P_W-1:0] prod;
  logic signed [PROD_W-1:0]  t1;
  logic signed [EDGE_W-1:0]  edge_c;
  logic signed [DEN_W-1:0]   den3;

  logic signed [COORD_W-1:0] res_cx, res_cy;
  logic signed [CROSS_W-1:0] res_area;
  logic [STAT_W-1:0]         res_st;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [EDGE_W-1:0]  c_new;

  logic                      div_start;
  logic signed [MOM_W-1:0]   div_num;
  div_stat_t                 div_stat;
  logic signed [COORD_W-1:0] div_q;

  logic s_fire;
  logic has_edge;

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign has_edge = (vertex_count != '0) && (vertex_count <= CNT_W'(MAX_VERTICES));

  // shared multiplier operand select
  always_comb begin
    case (state)
      S_M1: begin
        mul_a = MUL_A_W'(px);
        mul_b = MUL_B_W'(qy);
      end
      S_M2: begin
        mul_a = MUL_A_W'(qx);
        mul_b = MUL_B_W'(py);
      end
      S_M4: begin
        mul_a = MUL_A_W'(edge_c);
        mul_b = MUL_B_W'(px) + MUL_B_W'(qx);
      end
      S_M5: begin
        mul_a = MUL_A_W'(edge_c);
        mul_b = MUL_B_W'(py) + MUL_B_W'(qy);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    c_new = EDGE_W'(t1) - EDGE_W'(signed'(prod[PROD_W-1:0]));
  end

  assign div_start = (state == S_DXS) || (state == S_DYS);
  assign div_num   = (state == S_DXS) ? moment_x_sum : moment_y_sum;

  pcent_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (den3),
    .stat (div_stat),
    .quot (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cross_sum    <= '0;
      moment_x_sum <= '0;
      moment_y_sum <= '0;
      vertex_count <= '0;
      last_r       <= 1'b0;
      closed       <= 1'b0;
      first_x      <= '0;
      first_y      <= '0;
      prev_x       <= '0;
      prev_y       <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            if (vertex_count == '0) begin
              first_x <= s_tdata[15:0];
              first_y <= s_tdata[31:16];
            end
            px     <= prev_x;
            py     <= prev_y;
            qx     <= s_tdata[15:0];
            qy     <= s_tdata[31:16];
            prev_x <= s_tdata[15:0];
            prev_y <= s_tdata[31:16];
            if (vertex_count <= CNT_W'(MAX_VERTICES)) begin
              vertex_count <= vertex_count + 1'b1;
            end
            last_r <= s_tlast;
            if (has_edge) begin
              state <= S_M1;
            end else if (s_tlast) begin
              state <= S_CLOSE;
            end
          end
        end
        S_M1: begin
          prod  <= mul_a * mul_b;
          state <= S_M2;
        end
        S_M2: begin
          t1    <= prod[PROD_W-1:0];
          prod  <= mul_a * mul_b;
          state <= S_M3;
        end
        S_M3: begin
          edge_c    <= c_new;
          cross_sum <= cross_sum + CROSS_W'(c_new);
          state     <= S_M4;
        end
        S_M4: begin
          prod  <= mul_a * mul_b;
          state <= S_M5;
        end
        S_M5: begin
          moment_x_sum <= moment_x_sum + MOM_W'(prod);
          prod         <= mul_a * mul_b;
          state        <= S_M6;
        end
        S_M6: begin
          moment_y_sum <= moment_y_sum + MOM_W'(prod);
          if (closed) begin
            state <= S_CHK;
          end else if (last_r) begin
            state <= S_CLOSE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CLOSE: begin
          if (vertex_count > CNT_W'(MAX_VERTICES)) begin
            res_cx   <= '0;
            res_cy   <= '0;
            res_area <= '0;
            res_st   <= ST_TOO_MANY;
            state    <= S_OUT;
          end else begin
            // edge from the last vertex back to the first
            px     <= prev_x;
            py     <= prev_y;
            qx     <= first_x;
            qy     <= first_y;
            closed <= 1'b1;
            state  <= S_M1;
          end
        end
        S_CHK: begin
          res_area <= cross_sum;
          den3     <= (DEN_W'(cross_sum) <<< 1) + DEN_W'(cross_sum);
          if (cross_sum == '0) begin
            res_cx <= '0;
            res_cy <= '0;
            res_st <= ST_ZERO;
            state  <= S_OUT;
          end else begin
            res_st <= ST_OK;
            state  <= S_DXS;
          end
        end
        S_DXS: begin
          state <= S_DXW;
        end
        S_DXW: begin
          if (div_stat.done) begin
            res_cx <= div_q;
            state  <= S_DYS;
          end
        end
        S_DYS: begin
          state <= S_DYW;
        end
        S_DYW: begin
          if (div_stat.done) begin
            res_cy <= div_q;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata      <= {6'd0, res_st, res_area, res_cy, res_cx};
            m_tvalid     <= 1'b1;
            cross_sum    <= '0;
            moment_x_sum <= '0;
            moment_y_sum <= '0;
            vertex_count <= '0;
            last_r       <= 1'b0;
            closed       <= 1'b0;
            first_x      <= '0;
            first_y      <= '0;
            prev_x       <= '0;
            prev_y       <= '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/polygon_centroid_checker.sv
// ----------------------------------------------------------------------------
// polygon_centroid_checker
// port-level checks on the centroid result stream
// ----------------------------------------------------------------------------
module polygon_centroid_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);
  import pcent_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[73:72] == ST_ZERO |-> m_tdata[71:0] == '0)
    else $error("zero area result carries data");

  a_many: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[73:72] == ST_TOO_MANY |-> m_tdata[71:0] == '0)
    else $error("overflow result carries data");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[73:72] != 2'd3 && m_tdata[79:74] == '0)
    else $error("bad status or padding");

endmodule

bind polygon_centroid polygon_centroid_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
